>>> hw/rtl/two_register_cpu_core_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-register CPU core
// Shared property forms, sampled on clk; all but the last are disabled by rst.
// ----------------------------------------------------------------------------
`ifndef TWO_REGISTER_CPU_CORE_TOP_DEFINES_SVH
`define TWO_REGISTER_CPU_CORE_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define TRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define TRC_ASSERT_ALWAYS_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Types, field positions and ALU function codes of the two-register CPU core.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 15;
  localparam int MEM_WORDS  = 32768;
  localparam int MEM_ADDR_W = $clog2(MEM_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // instruction fields
  localparam int INSTR_C_BIT = 15;
  localparam int COMP_LSB    = 6;
  localparam int COMP_W      = 7;
  localparam int DEST_LSB    = 3;
  localparam int DEST_W      = 3;
  localparam int JUMP_LSB    = 0;
  localparam int JUMP_W      = 3;

  // destination bits
  localparam int DEST_M = 0;
  localparam int DEST_D = 1;
  localparam int DEST_A = 2;

  // jump condition bits
  localparam int JUMP_GT = 0;
  localparam int JUMP_EQ = 1;
  localparam int JUMP_LT = 2;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [DEST_W-1:0] dest_t;
  typedef logic [JUMP_W-1:0] jump_t;

  // ALU function codes (a bit plus six control bits)
  localparam comp_t COMP_ZERO  = 7'h2A;
  localparam comp_t COMP_ONE   = 7'h3F;
  localparam comp_t COMP_MONE  = 7'h3A;
  localparam comp_t COMP_D     = 7'h0C;
  localparam comp_t COMP_A     = 7'h30;
  localparam comp_t COMP_M     = 7'h70;
  localparam comp_t COMP_NOT_D = 7'h0D;
  localparam comp_t COMP_NOT_A = 7'h31;
  localparam comp_t COMP_NOT_M = 7'h71;
  localparam comp_t COMP_NEG_D = 7'h0F;
  localparam comp_t COMP_NEG_A = 7'h33;
  localparam comp_t COMP_NEG_M = 7'h73;
  localparam comp_t COMP_D_INC = 7'h1F;
  localparam comp_t COMP_A_INC = 7'h37;
  localparam comp_t COMP_M_INC = 7'h77;
  localparam comp_t COMP_D_DEC = 7'h0E;
  localparam comp_t COMP_A_DEC = 7'h32;
  localparam comp_t COMP_M_DEC = 7'h72;
  localparam comp_t COMP_D_ADD_A = 7'h02;
  localparam comp_t COMP_D_ADD_M = 7'h42;
  localparam comp_t COMP_D_SUB_A = 7'h13;
  localparam comp_t COMP_D_SUB_M = 7'h53;
  localparam comp_t COMP_A_SUB_D = 7'h07;
  localparam comp_t COMP_M_SUB_D = 7'h47;
  localparam comp_t COMP_D_AND_A = 7'h00;
  localparam comp_t COMP_D_AND_M = 7'h40;
  localparam comp_t COMP_D_OR_A  = 7'h15;
  localparam comp_t COMP_D_OR_M  = 7'h55;

  typedef struct packed {
    comp_t comp;
    jump_t jump;
  } alu_ctrl_t;

  typedef struct packed {
    logic zero;
    logic neg;
    logic taken;
  } alu_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/trc_if.sv
// ----------------------------------------------------------------------------
// trc_if
// Valid/ready channels for instruction items and execution results.
// ----------------------------------------------------------------------------
`default_nettype none

interface trc_instr_if import trc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t instruction;
  word_t memory_in;

  modport source (output valid, output instruction, output memory_in, input ready);
  modport sink   (input valid, input instruction, input memory_in, output ready);
endinterface

interface trc_result_if import trc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t memory_out;
  logic  memory_write;
  addr_t write_address;
  addr_t read_address;
  addr_t next_pc;

  modport source (output valid, output memory_out, output memory_write,
                  output write_address, output read_address, output next_pc,
                  input ready);
  modport sink   (input valid, input memory_out, input memory_write,
                  input write_address, input read_address, input next_pc,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/two_register_cpu_core_top.sv
// ----------------------------------------------------------------------------
// two_register_cpu_core_top
// Executes one 16-bit instruction per transfer on instr_ch, together with the
// data word read at the current A address, and returns one result per
// instruction on result_ch: the ALU value and write strobe for data memory,
// the write address (A before the instruction), the read address (A after
// it) and the next instruction address. A, D and PC live here and clear on
// reset. An instruction is captured in an input register and executed from
// there into the result register; one instruction is taken every cycle while
// the result is not stalled, and a stalled result holds the pipe only while
// the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module two_register_cpu_core_top import trc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  trc_instr_if.sink     instr_ch,
  trc_result_if.source  result_ch
);

  // input register
  logic  s1_valid;
  word_t s1_instr;
  word_t s1_mem;
  logic  s1_adv;

  // architectural state
  word_t a_reg;
  word_t d_reg;
  addr_t pc_reg;
  word_t a_next;
  word_t d_next;
  addr_t pc_next;

  // execute
  logic       is_c;
  dest_t      dest;
  alu_ctrl_t  alu_ctrl;
  word_t      alu_result;
  alu_flags_t alu_flags;
  word_t      mem_out_next;

  assign s1_adv         = s1_valid && (!result_ch.valid || result_ch.ready);
  assign instr_ch.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr_ch.ready) begin
      s1_valid <= instr_ch.valid;
    end
    if (instr_ch.valid && instr_ch.ready) begin
      s1_instr <= instr_ch.instruction;
      s1_mem   <= instr_ch.memory_in;
    end
  end

  assign is_c          = s1_instr[INSTR_C_BIT];
  assign dest          = s1_instr[DEST_LSB +: DEST_W];
  assign alu_ctrl.comp = s1_instr[COMP_LSB +: COMP_W];
  assign alu_ctrl.jump = s1_instr[JUMP_LSB +: JUMP_W];

  trc_alu u_alu (
    .ctrl   (alu_ctrl),
    .d      (d_reg),
    .a      (a_reg),
    .m      (s1_mem),
    .result (alu_result),
    .flags  (alu_flags)
  );

  always_comb begin
    a_next       = a_reg;
    d_next       = d_reg;
    pc_next      = pc_reg + addr_t'(1);
    mem_out_next = '0;
    if (!is_c) begin
      a_next = word_t'(s1_instr[ADDR_W-1:0]);
    end else begin
      mem_out_next = alu_result;
      if (dest[DEST_D]) begin
        d_next = alu_result;
      end
      if (dest[DEST_A]) begin
        a_next = alu_result;
      end
      // jump target is A as it was before this instruction
      if (alu_flags.taken) begin
        pc_next = a_reg[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg  <= '0;
      d_reg  <= '0;
      pc_reg <= '0;
    end else if (s1_adv) begin
      a_reg  <= a_next;
      d_reg  <= d_next;
      pc_reg <= pc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (s1_adv) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
    if (s1_adv) begin
      result_ch.memory_out    <= mem_out_next;
      result_ch.memory_write  <= is_c && dest[DEST_M];
      result_ch.write_address <= addr_t'(a_reg[MEM_ADDR_W-1:0]);
      result_ch.read_address  <= addr_t'(a_next[MEM_ADDR_W-1:0]);
      result_ch.next_pc       <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/trc_alu.sv
// ----------------------------------------------------------------------------
// trc_alu
// Computes one function of D, A or M and evaluates the jump condition.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_alu import trc_pkg::*; (
  input  alu_ctrl_t  ctrl,
  input  word_t      d,
  input  word_t      a,
  input  word_t      m,
  output word_t      result,
  output alu_flags_t flags
);

  always_comb begin
    unique case (ctrl.comp)
      COMP_ZERO:    result = '0;
      COMP_ONE:     result = word_t'(1);
      COMP_MONE:    result = '1;
      COMP_D:       result = d;
      COMP_A:       result = a;
      COMP_M:       result = m;
      COMP_NOT_D:   result = ~d;
      COMP_NOT_A:   result = ~a;
      COMP_NOT_M:   result = ~m;
      COMP_NEG_D:   result = -d;
      COMP_NEG_A:   result = -a;
      COMP_NEG_M:   result = -m;
      COMP_D_INC:   result = d + word_t'(1);
      COMP_A_INC:   result = a + word_t'(1);
      COMP_M_INC:   result = m + word_t'(1);
      COMP_D_DEC:   result = d - word_t'(1);
      COMP_A_DEC:   result = a - word_t'(1);
      COMP_M_DEC:   result = m - word_t'(1);
      COMP_D_ADD_A: result = d + a;
      COMP_D_ADD_M: result = d + m;
      COMP_D_SUB_A: result = d - a;
      COMP_D_SUB_M: result = d - m;
      COMP_A_SUB_D: result = a - d;
      COMP_M_SUB_D: result = m - d;
      COMP_D_AND_A: result = d & a;
      COMP_D_AND_M: result = d & m;
      COMP_D_OR_A:  result = d | a;
      COMP_D_OR_M:  result = d | m;
      default:      result = '0;
    endcase
  end

  always_comb begin
    flags.zero  = (result == '0);
    flags.neg   = result[WORD_W-1];
    flags.taken = (ctrl.jump[JUMP_LT] && flags.neg) ||
                  (ctrl.jump[JUMP_EQ] && flags.zero) ||
                  (ctrl.jump[JUMP_GT] && !flags.neg && !flags.zero);
  end

endmodule

`default_nettype wire

>>> hw/rtl/trc_checker.sv
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks of the CPU core pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_register_cpu_core_top_defines.svh"

module trc_checker import trc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire word_t memory_out,
  input wire logic  memory_write,
  input wire addr_t write_address,
  input wire addr_t read_address,
  input wire addr_t next_pc
);

  `TRC_ASSERT_ALWAYS_NXT(a_reset_clears_out, rst, !out_valid, "result valid after reset")

  `TRC_ASSERT_IMP(a_ready_when_out_empty, !out_valid, in_ready, "input blocked with empty output")

  `TRC_ASSERT_IMP(a_result_follows, in_valid && in_ready, ##2 out_valid, "no result two cycles after transfer")

  `TRC_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(memory_out) && $stable(memory_write) && $stable(write_address) && $stable(read_address) && $stable(next_pc), "stalled result changed")

endmodule

bind two_register_cpu_core_top trc_checker u_trc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (instr_ch.valid),
  .in_ready      (instr_ch.ready),
  .out_valid     (result_ch.valid),
  .out_ready     (result_ch.ready),
  .memory_out    (result_ch.memory_out),
  .memory_write  (result_ch.memory_write),
  .write_address (result_ch.write_address),
  .read_address  (result_ch.read_address),
  .next_pc       (result_ch.next_pc)
);

`default_nettype wire

>>> sim/two_register_cpu_core_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_register_cpu_core_top_tb
// Drives instruction/data-word pairs into the core and predicts the A, D and
// PC registers alongside it. Every result transfer is checked field by field
// against the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------

module two_register_cpu_core_top_tb;
  import trc_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 15;

  typedef struct packed {
    word_t memory_out;
    logic  memory_write;
    addr_t write_address;
    addr_t read_address;
    addr_t next_pc;
  } exec_result_t;

  comp_t legal_comps [0:27] = '{
    COMP_ZERO, COMP_ONE, COMP_MONE, COMP_D, COMP_A, COMP_M,
    COMP_NOT_D, COMP_NOT_A, COMP_NOT_M, COMP_NEG_D, COMP_NEG_A, COMP_NEG_M,
    COMP_D_INC, COMP_A_INC, COMP_M_INC, COMP_D_DEC, COMP_A_DEC, COMP_M_DEC,
    COMP_D_ADD_A, COMP_D_ADD_M, COMP_D_SUB_A, COMP_D_SUB_M, COMP_A_SUB_D,
    COMP_M_SUB_D, COMP_D_AND_A, COMP_D_AND_M, COMP_D_OR_A, COMP_D_OR_M
  };

  class core_exec_checker;
    word_t        a_q;
    word_t        d_q;
    addr_t        pc_q;
    exec_result_t pending_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    function new();
      a_q          = '0;
      d_q          = '0;
      pc_q         = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function word_t alu_eval(comp_t c, word_t d, word_t a, word_t m);
      case (c)
        COMP_ZERO:    return '0;
        COMP_ONE:     return 16'd1;
        COMP_MONE:    return 16'hFFFF;
        COMP_D:       return d;
        COMP_A:       return a;
        COMP_M:       return m;
        COMP_NOT_D:   return ~d;
        COMP_NOT_A:   return ~a;
        COMP_NOT_M:   return ~m;
        COMP_NEG_D:   return 16'd0 - d;
        COMP_NEG_A:   return 16'd0 - a;
        COMP_NEG_M:   return 16'd0 - m;
        COMP_D_INC:   return d + 16'd1;
        COMP_A_INC:   return a + 16'd1;
        COMP_M_INC:   return m + 16'd1;
        COMP_D_DEC:   return d - 16'd1;
        COMP_A_DEC:   return a - 16'd1;
        COMP_M_DEC:   return m - 16'd1;
        COMP_D_ADD_A: return d + a;
        COMP_D_ADD_M: return d + m;
        COMP_D_SUB_A: return d - a;
        COMP_D_SUB_M: return d - m;
        COMP_A_SUB_D: return a - d;
        COMP_M_SUB_D: return m - d;
        COMP_D_AND_A: return d & a;
        COMP_D_AND_M: return d & m;
        COMP_D_OR_A:  return d | a;
        COMP_D_OR_M:  return d | m;
        default:      return '0;
      endcase
    endfunction

    function addr_t mem_index(word_t v);
      return addr_t'(32'(v[ADDR_W-1:0]) % MEM_WORDS);
    endfunction

    // execute one instruction on the shadow registers, queue its result
    function void note_instr(word_t instr, word_t m);
      exec_result_t r;
      word_t        old_a;
      word_t        val;
      dest_t        dst;
      jump_t        jmp;
      logic         taken;
      old_a = a_q;
      val   = '0;
      dst   = '0;
      if (!instr[INSTR_C_BIT]) begin
        a_q  = {1'b0, instr[ADDR_W-1:0]};
        pc_q = pc_q + 1'b1;
      end else begin
        dst = instr[DEST_LSB +: DEST_W];
        jmp = instr[JUMP_LSB +: JUMP_W];
        val = alu_eval(instr[COMP_LSB +: COMP_W], d_q, old_a, m);
        if (dst[DEST_D]) d_q = val;
        if (dst[DEST_A]) a_q = val;
        taken = (jmp[JUMP_LT] && val[WORD_W-1]) || (jmp[JUMP_EQ] && val == '0) ||
                (jmp[JUMP_GT] && !val[WORD_W-1] && val != '0);
        pc_q = taken ? old_a[ADDR_W-1:0] : pc_q + 1'b1;
      end
      r.memory_out    = val;
      r.memory_write  = instr[INSTR_C_BIT] && dst[DEST_M];
      r.write_address = mem_index(old_a);
      r.read_address  = mem_index(a_q);
      r.next_pc       = pc_q;
      pending_results.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("result %0d: %s got %h, expected %h", results_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected transfer, memory_out", got.memory_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.memory_out != want.memory_out)
          report("memory_out", got.memory_out, want.memory_out);
        if (got.memory_write != want.memory_write)
          report("memory_write", got.memory_write, want.memory_write);
        if (got.write_address != want.write_address)
          report("write_address", got.write_address, want.write_address);
        if (got.read_address != want.read_address)
          report("read_address", got.read_address, want.read_address);
        if (got.next_pc != want.next_pc)
          report("next_pc", got.next_pc, want.next_pc);
      end
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady;
  int unsigned cycle_count;
  core_exec_checker checker_h;

  trc_instr_if  instr_ch ();
  trc_result_if result_ch ();

  two_register_cpu_core_top dut (
    .clk       (clk),
    .rst       (rst),
    .instr_ch  (instr_ch),
    .result_ch (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic is_legal(comp_t c);
    foreach (legal_comps[i])
      if (legal_comps[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic word_t c_instr(comp_t c, dest_t dst, jump_t jmp, logic [1:0] spare);
    return {1'b1, spare, c, dst, jmp};
  endfunction

  function automatic word_t a_instr(addr_t v);
    return {1'b0, v};
  endfunction

  function automatic word_t random_instr();
    int unsigned pick;
    comp_t       c;
    pick = $urandom_range(99);
    if (pick < 30) return a_instr(15'($urandom));
    if (pick < 40) return 16'($urandom);
    if (pick < 45) begin
      c = 7'($urandom);
      while (is_legal(c)) c = 7'($urandom);
    end else begin
      c = legal_comps[$urandom_range(27)];
    end
    return c_instr(c, 3'($urandom), 3'($urandom), 2'($urandom));
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_instr(word_t instr, word_t m);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid       <= 1'b1;
    instr_ch.instruction <= instr;
    instr_ch.memory_in   <= m;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
  endtask

  // result stalls
  always @(posedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // transfer monitor: both channels sampled at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready)
        checker_h.check_result('{result_ch.memory_out, result_ch.memory_write,
                                 result_ch.write_address, result_ch.read_address,
                                 result_ch.next_pc});
      if (instr_ch.valid && instr_ch.ready)
        checker_h.note_instr(instr_ch.instruction, instr_ch.memory_in);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_register_cpu_core_top_tb NOT OK");
    $finish;
  end

  initial begin
    checker_h            = new();
    rst                  = 1'b1;
    steady               = 1'b0;
    instr_ch.valid       = 1'b0;
    instr_ch.instruction = '0;
    instr_ch.memory_in   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // largest A, copy to D, unconditional jump to the top PC, then PC wraps
    send_instr(a_instr(15'h7FFF), 16'hFFFF);
    send_instr(c_instr(COMP_A, 3'b010, 3'b000, 2'b00), 16'hFFFF);
    send_instr(c_instr(COMP_ZERO, 3'b000, 3'b111, 2'b00), 16'h0000);
    send_instr(a_instr(15'h0000), 16'h0000);
    // A gets bit 15 set; spare bits 14:13 must be ignored
    send_instr(c_instr(COMP_MONE, 3'b111, 3'b000, 2'b11), 16'h8000);
    // jump target is old A cut to 15 bits
    send_instr(c_instr(COMP_A_INC, 3'b001, 3'b010, 2'b01), 16'h7FFF);
    send_instr(c_instr(COMP_D_ADD_M, 3'b010, 3'b001, 2'b10), 16'h0001);
    // undefined function code yields zero
    send_instr(c_instr(7'h7F, 3'b010, 3'b010, 2'b00), 16'hFFFF);
    foreach (legal_comps[i])
      send_instr(c_instr(legal_comps[i], 3'($urandom), 3'($urandom), 2'($urandom)),
                 random_word());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= (i >= 250 && i < 350);
      send_instr(random_instr(), random_word());
    end
    instr_ch.valid <= 1'b0;
    steady         <= 1'b0;

    while (checker_h.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_h.mismatches == 0)
      $display("two_register_cpu_core_top_tb OK");
    else
      $display("two_register_cpu_core_top_tb NOT OK");
    $finish;
  end

endmodule
